@@ rtl/tccm_pkg.sv @@
// Shared types and constants for the two-channel coincidence matcher.
`default_nettype none
package tccm_pkg;
    localparam int unsigned TsW = 48;
    localparam int unsigned ValW = 16;
    localparam int unsigned DiffW = 17;
    localparam logic [ValW-1:0] WindowReset = 16'd100;

    typedef struct packed {
        logic            channel;
        logic [TsW-1:0]  timestamp;
        logic [ValW-1:0] energy;
        logic [ValW-1:0] fit_energy;
        logic [ValW-1:0] shape_value;
    } t_event;

    typedef struct packed {
        logic             matched;
        logic [ValW-1:0]  ch0_energy;
        logic [ValW-1:0]  ch1_energy;
        logic [ValW-1:0]  ch0_fit;
        logic [ValW-1:0]  ch1_fit;
        logic [ValW-1:0]  ch0_shape;
        logic [ValW-1:0]  ch1_shape;
        logic [DiffW-1:0] time_difference;
    } t_result;
endpackage
`default_nettype wire

@@ rtl/tccm_if.sv @@
// Valid/ready channel interfaces for events, results and configuration.
`default_nettype none
interface tccm_event_if;
    logic valid;
    logic ready;
    tccm_pkg::t_event data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tccm_result_if;
    logic valid;
    logic ready;
    tccm_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tccm_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tccm_front.sv @@
// Front end: two-entry event queue between the input channel and the matcher.
`default_nettype none
module tccm_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tccm_pkg::t_event i_event,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output tccm_pkg::t_event     o_event
);
    import tccm_pkg::*;

    t_event     r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_event = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop && o_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop && o_valid) begin
                r_rptr <= ~r_rptr;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_event;
        end
    end
endmodule
`default_nettype wire

@@ rtl/tccm_hist.sv @@
// One channel's event history: shift-in insert, compare lanes, compacting remove.
`default_nettype none
module tccm_hist #(
    parameter int unsigned Depth = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [47:0]             i_ts,
    input  wire logic [15:0]             i_window,
    output logic [Depth-1:0]             o_hit,
    input  wire logic                    i_insert,
    input  wire tccm_pkg::t_event        i_event,
    input  wire logic                    i_remove,
    input  wire logic [Depth-1:0]        i_sel,
    output logic [47:0]                  o_ts,
    output logic [15:0]                  o_energy,
    output logic [15:0]                  o_fit,
    output logic [15:0]                  o_shape
);
    import tccm_pkg::*;

    localparam int unsigned CntW = $clog2(Depth + 1);

    logic [TsW-1:0]  r_ts  [Depth];
    logic [ValW-1:0] r_en  [Depth];
    logic [ValW-1:0] r_fit [Depth];
    logic [ValW-1:0] r_shp [Depth];
    logic [CntW-1:0] r_cnt;
    logic [Depth-1:0] below;

    always_comb begin
        o_ts = '0;
        o_energy = '0;
        o_fit = '0;
        o_shape = '0;
        for (int k = 0; k < Depth; k++) begin
            if (i_sel[k]) begin
                o_ts     = o_ts | r_ts[k];
                o_energy = o_energy | r_en[k];
                o_fit    = o_fit | r_fit[k];
                o_shape  = o_shape | r_shp[k];
            end
        end
    end

    for (genvar g = 0; g < Depth; g++) begin : g_lane
        logic [TsW-1:0] ad;
        assign ad = (i_ts > r_ts[g]) ? (i_ts - r_ts[g]) : (r_ts[g] - i_ts);
        assign o_hit[g] = (r_cnt > CntW'(g)) && (ad < {32'd0, i_window});
        assign below[g] = |(i_sel & ((Depth'(1) << g) - Depth'(1))) || i_sel[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_insert) begin
            if (r_cnt != CntW'(Depth)) begin
                r_cnt <= r_cnt + CntW'(1);
            end
        end else if (i_remove) begin
            r_cnt <= r_cnt - CntW'(1);
        end
        for (int k = 0; k < Depth; k++) begin
            if (i_insert) begin
                if (k == 0) begin
                    r_ts[k]  <= i_event.timestamp;
                    r_en[k]  <= i_event.energy;
                    r_fit[k] <= i_event.fit_energy;
                    r_shp[k] <= i_event.shape_value;
                end else begin
                    r_ts[k]  <= r_ts[(k+Depth-1) % Depth];
                    r_en[k]  <= r_en[(k+Depth-1) % Depth];
                    r_fit[k] <= r_fit[(k+Depth-1) % Depth];
                    r_shp[k] <= r_shp[(k+Depth-1) % Depth];
                end
            end else if (i_remove && below[k] && k + 1 < Depth) begin
                r_ts[k]  <= r_ts[(k+1) % Depth];
                r_en[k]  <= r_en[(k+1) % Depth];
                r_fit[k] <= r_fit[(k+1) % Depth];
                r_shp[k] <= r_shp[(k+1) % Depth];
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/tccm_back.sv @@
// Back end: compare against the other history, pick the newest hit, update, emit result.
`default_nettype none
module tccm_back #(
    parameter int unsigned Depth = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [15:0]      i_window,
    input  wire logic             i_valid,
    output logic                  o_pop,
    input  wire tccm_pkg::t_event i_event,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output tccm_pkg::t_result     o_result,
    output logic                  o_busy
);
    import tccm_pkg::*;

    typedef enum logic [1:0] {
        S_CMP = 2'b01,
        S_UPD = 2'b10
    } t_state;

    t_state r_state;
    logic [Depth-1:0] hit0, hit1, r_sel;
    logic [Depth-1:0] hits, pick;
    logic r_match;
    logic [TsW-1:0]  ts0, ts1;
    logic [ValW-1:0] e0, e1, f0, f1, s0, s1;
    logic [TsW-1:0]  ots;
    logic [ValW-1:0] oen, ofit, oshp;
    logic ins0, ins1, rem0, rem1, upd;
    t_result res;

    assign hits = i_event.channel ? hit0 : hit1;
    always_comb begin
        pick = '0;
        for (int k = Depth - 1; k >= 0; k--) begin
            if (hits[k]) begin
                pick = '0;
                pick[k] = 1'b1;
            end
        end
    end

    assign upd  = (r_state == S_UPD) && (!o_valid || i_ready);
    assign ins0 = upd && !r_match && !i_event.channel;
    assign ins1 = upd && !r_match && i_event.channel;
    assign rem0 = upd && r_match && i_event.channel;
    assign rem1 = upd && r_match && !i_event.channel;
    assign o_pop  = upd;
    assign o_busy = (r_state == S_UPD) || o_valid;

    tccm_hist #(.Depth(Depth)) u_h0 (
        .i_clk, .i_rst_n, .i_ts(i_event.timestamp), .i_window, .o_hit(hit0),
        .i_insert(ins0), .i_event, .i_remove(rem0), .i_sel(r_sel),
        .o_ts(ts0), .o_energy(e0), .o_fit(f0), .o_shape(s0)
    );
    tccm_hist #(.Depth(Depth)) u_h1 (
        .i_clk, .i_rst_n, .i_ts(i_event.timestamp), .i_window, .o_hit(hit1),
        .i_insert(ins1), .i_event, .i_remove(rem1), .i_sel(r_sel),
        .o_ts(ts1), .o_energy(e1), .o_fit(f1), .o_shape(s1)
    );

    assign ots  = i_event.channel ? ts0 : ts1;
    assign oen  = i_event.channel ? e0 : e1;
    assign ofit = i_event.channel ? f0 : f1;
    assign oshp = i_event.channel ? s0 : s1;

    always_comb begin
        res = '0;
        if (r_match) begin
            res.matched = 1'b1;
            if (i_event.channel) begin
                res.ch0_energy = oen;  res.ch1_energy = i_event.energy;
                res.ch0_fit = ofit;    res.ch1_fit = i_event.fit_energy;
                res.ch0_shape = oshp;  res.ch1_shape = i_event.shape_value;
                res.time_difference = DiffW'(i_event.timestamp - ots);
            end else begin
                res.ch0_energy = i_event.energy;      res.ch1_energy = oen;
                res.ch0_fit = i_event.fit_energy;     res.ch1_fit = ofit;
                res.ch0_shape = i_event.shape_value;  res.ch1_shape = oshp;
                res.time_difference = DiffW'(ots - i_event.timestamp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CMP;
            o_valid <= 1'b0;
        end else begin
            if (upd) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CMP: if (i_valid) begin
                    r_state <= S_UPD;
                end
                S_UPD: if (upd) begin
                    r_state <= S_CMP;
                end
                default: r_state <= S_CMP;
            endcase
        end
        if (r_state == S_CMP) begin
            r_sel   <= pick;
            r_match <= |hits;
        end
        if (upd) begin
            o_result <= res;
        end
    end
endmodule
`default_nettype wire

@@ rtl/two_channel_coincidence_matcher_top.sv @@
// Top level of the two-channel coincidence matcher.
// Usage:
//   i_evt carries one event (channel, timestamp, energy, fit, shape) per transfer.
//   o_res carries one result per event: the matched pair, or all zeros on a miss.
//   i_cfg writes the coincidence window; write it only while the block is idle.
// Timing:
//   A two-entry queue takes events while the matcher works. Each event passes
//   through the matcher states S_CMP, which compares it against every entry of
//   the other channel's history in parallel and picks the newest hit, and S_UPD,
//   which removes or inserts an entry and loads the output register, waiting
//   while o_res is stalled. The matcher finishes one event before the next.
// Reset:
//   Histories empty, window 100, no result pending.
// Stall:
//   While o_res is stalled the matcher holds its finished event at the head of
//   the queue, which takes one more event before i_evt.ready drops.
`default_nettype none
module two_channel_coincidence_matcher_top #(
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tccm_event_if.sink   i_evt,
    tccm_cfg_if.sink     i_cfg,
    tccm_result_if.source o_res
);
    import tccm_pkg::*;

    logic [15:0] r_window;
    logic        q_valid, q_pop, busy;
    t_event      q_event;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WindowReset;
        end else if (i_cfg.valid) begin
            r_window <= i_cfg.data;
        end
    end

    tccm_front u_front (
        .i_clk, .i_rst_n, .i_valid(i_evt.valid), .o_ready(i_evt.ready),
        .i_event(i_evt.data), .o_valid(q_valid), .i_pop(q_pop), .o_event(q_event)
    );

    tccm_back #(.Depth(HISTORY_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_window(r_window), .i_valid(q_valid), .o_pop(q_pop),
        .i_event(q_event), .o_valid(o_res.valid), .i_ready(o_res.ready),
        .o_result(o_res.data), .o_busy(busy)
    );

`ifndef ASSERT_OFF
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_res.valid) else $error("result missing after update");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.matched) |-> (o_res.data.time_difference == '0))
        else $error("miss result not zero");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> busy) else $error("busy flag low with result pending");
`endif
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the two-channel coincidence matcher: directed and random events checked against a predictor.
`default_nettype none
module tb;
    import tccm_pkg::*;

    localparam int Depth = 16;
    localparam int CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tccm_event_if evt_ch ();
    tccm_cfg_if cfg_ch ();
    tccm_result_if res_ch ();

    two_channel_coincidence_matcher_top #(.HISTORY_DEPTH(Depth)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_evt(evt_ch.sink),
        .i_cfg(cfg_ch.sink),
        .o_res(res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [47:0] hist_t [2][Depth];
    logic [15:0] hist_e [2][Depth];
    logic [15:0] hist_f [2][Depth];
    logic [15:0] hist_s [2][Depth];
    int hist_n [2];
    logic [15:0] window;

    t_result pending_results [$];
    int errors = 0;
    int n_events = 0;
    int n_matches = 0;
    int n_results = 0;
    int cycles = 0;
    bit send_idles = 1'b1;
    bit sink_idles = 1'b1;

    function automatic t_result predict_pair(t_event ev);
        t_result r;
        int o;
        logic [47:0] u;
        logic [47:0] ad;
        r = '0;
        o = ev.channel ? 0 : 1;
        for (int i = 0; i < hist_n[o]; i++) begin
            u = hist_t[o][i];
            ad = (ev.timestamp > u) ? ev.timestamp - u : u - ev.timestamp;
            if (ad < {32'd0, window}) begin
                r.matched = 1'b1;
                if (ev.channel == 1'b0) begin
                    r.ch0_energy = ev.energy; r.ch1_energy = hist_e[o][i];
                    r.ch0_fit = ev.fit_energy; r.ch1_fit = hist_f[o][i];
                    r.ch0_shape = ev.shape_value; r.ch1_shape = hist_s[o][i];
                    r.time_difference = 17'(u - ev.timestamp);
                end else begin
                    r.ch0_energy = hist_e[o][i]; r.ch1_energy = ev.energy;
                    r.ch0_fit = hist_f[o][i]; r.ch1_fit = ev.fit_energy;
                    r.ch0_shape = hist_s[o][i]; r.ch1_shape = ev.shape_value;
                    r.time_difference = 17'(ev.timestamp - u);
                end
                for (int k = i; k + 1 < hist_n[o]; k++) begin
                    hist_t[o][k] = hist_t[o][k+1]; hist_e[o][k] = hist_e[o][k+1];
                    hist_f[o][k] = hist_f[o][k+1]; hist_s[o][k] = hist_s[o][k+1];
                end
                hist_n[o]--;
                return r;
            end
        end
        o = int'(ev.channel);
        for (int k = Depth - 1; k > 0; k--) begin
            hist_t[o][k] = hist_t[o][k-1]; hist_e[o][k] = hist_e[o][k-1];
            hist_f[o][k] = hist_f[o][k-1]; hist_s[o][k] = hist_s[o][k-1];
        end
        hist_t[o][0] = ev.timestamp; hist_e[o][0] = ev.energy;
        hist_f[o][0] = ev.fit_energy; hist_s[o][0] = ev.shape_value;
        if (hist_n[o] < Depth) hist_n[o]++;
        return r;
    endfunction

    task automatic send_event(t_event ev);
        while (send_idles && $urandom_range(99) < 20) begin
            evt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data <= ev;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_pair(ev));
        if (ev.channel == 1'b0 || ev.channel == 1'b1) n_events++;
    endtask

    task automatic wait_drained();
        evt_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_window(logic [15:0] w);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        window = w;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_event make_event(bit ch, logic [47:0] ts);
        t_event ev;
        ev.channel = ch;
        ev.timestamp = ts;
        ev.energy = 16'($urandom);
        ev.fit_energy = 16'($urandom);
        ev.shape_value = 16'($urandom);
        return ev;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, res_ch.data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.matched) n_matches++;
                if (res_ch.data !== want) begin
                    $display("%0t: result mismatch expected %h actual %h",
                        $time, want, res_ch.data);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= !(sink_idles && $urandom_range(99) < 20);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_extremes();
        t_event ev;
        write_window(16'd100);
        send_event(make_event(1'b0, 48'd0));
        send_event(make_event(1'b1, 48'd99));
        send_event(make_event(1'b1, 48'hFFFF_FFFF_FFFF));
        ev = make_event(1'b0, 48'hFFFF_FFFF_FF9C);
        ev.energy = 16'hFFFF; ev.fit_energy = 16'h8000; ev.shape_value = 16'h7FFF;
        send_event(ev);
        ev = make_event(1'b0, 48'hFFFF_FFFF_FF9D);
        ev.energy = 16'h0; ev.fit_energy = 16'h7FFF; ev.shape_value = 16'h8000;
        send_event(ev);
        send_event(make_event(1'b1, 48'd1000));
        send_event(make_event(1'b0, 48'd1000));
    endtask

    task automatic test_window_extremes();
        write_window(16'd0);
        send_event(make_event(1'b0, 48'd5000));
        send_event(make_event(1'b1, 48'd5000));
        write_window(16'hFFFF);
        send_event(make_event(1'b0, 48'd5000 + 48'd65534));
        send_event(make_event(1'b1, 48'd200000));
        send_event(make_event(1'b0, 48'd200000 - 48'd65534));
        write_window(16'd1);
        send_event(make_event(1'b1, 48'd300000));
        send_event(make_event(1'b0, 48'd300000));
    endtask

    task automatic test_full_history();
        write_window(16'd10);
        for (int i = 0; i < 18; i++)
            send_event(make_event(1'b0, 48'd900000 + 48'(i) * 48'd100));
        send_event(make_event(1'b1, 48'd900000));
        send_event(make_event(1'b1, 48'd900000 + 48'd1700));
        send_event(make_event(1'b1, 48'd900000 + 48'd800));
    endtask

    task automatic test_random(int count, logic [15:0] w);
        logic [47:0] base;
        write_window(w);
        base = 48'({$urandom, $urandom});
        if (base > 48'hFFFF_FFF0_0000) base = base - 48'h10_0000;
        for (int i = 0; i < count; i++) begin
            base = base + 48'($urandom_range(3 * w + 4));
            if ($urandom_range(9) == 0)
                send_event(make_event(1'($urandom), 48'({$urandom, $urandom})));
            else
                send_event(make_event(1'($urandom), base));
        end
    endtask

    initial begin
        evt_ch.valid = 1'b0;
        evt_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        window = WindowReset;
        hist_n[0] = 0;
        hist_n[1] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_window_extremes();
        test_full_history();
        test_random(120, 16'd100);
        send_idles = 1'b0;
        sink_idles = 1'b0;
        test_random(80, 16'd500);
        send_idles = 1'b1;
        sink_idles = 1'b1;
        test_random(100, 16'd20);
        test_random(60, 16'hFFFF);
        test_random(40, 16'd1);
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d events, %0d results, %0d coincidences,", n_events, n_results,
            n_matches);
        $display("windows from 0 to 65535, full histories and both stall patterns.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
